// ===== hdl/bounded_top_k_heap_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bounded top-k heap
// ---------------------------------------------------------------------------
`ifndef BOUNDED_TOP_K_HEAP_MACROS_SVH
`define BOUNDED_TOP_K_HEAP_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define BTK_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define BTK_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/btk_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounded top-k heap package
// State codes, CSR indices, field widths and the entry type used by the heap module.
// ---------------------------------------------------------------------------
package btk_pkg;
   localparam int KEY_W  = 32;
   localparam int IDX_W  = 24;
   localparam int SLOT_W = 6;
   localparam int CAP_W  = 7;

   localparam logic [0:0] CSR_KEEP_LARGEST    = 1'b0;
   localparam logic [0:0] CSR_CAPACITY_IN_USE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [IDX_W-1:0]  first;
      logic [IDX_W-1:0]  second;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST_RD,
      ST_LAST_WAIT,
      ST_SINK_RD,
      ST_SINK_WAIT,
      ST_SINK_CMP,
      ST_BUB_RD,
      ST_BUB_WAIT,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_DONE
   } state_type;
endpackage

// ===== hdl/bounded_top_k_heap.sv =====
// ---------------------------------------------------------------------------
// Bounded top-k heap
// Keeps the best candidates of a stream in a binary heap held in one RAM.
// ---------------------------------------------------------------------------
// One word is taken at a time: busy rises on start and falls once rsp_valid
// has pulsed for one cycle with no way to hold it off. Each word's heap walk
// is paced by the single read port of the entry RAM.
`include "bounded_top_k_heap_macros.svh"
module bounded_top_k_heap #(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [btk_pkg::KEY_W-1:0]   req_key_value,
   input  logic [btk_pkg::IDX_W-1:0]   req_first_index,
   input  logic [btk_pkg::IDX_W-1:0]   req_second_index,
   output logic                        rsp_valid,
   output logic                        rsp_accepted,
   output logic [btk_pkg::SLOT_W-1:0]  rsp_slot_number,
   output logic [btk_pkg::KEY_W-1:0]   rsp_head_key,
   output logic [btk_pkg::IDX_W-1:0]   rsp_head_first_index,
   output logic [btk_pkg::IDX_W-1:0]   rsp_head_second_index,
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [btk_pkg::CAP_W-1:0]   csr_data
);
   import btk_pkg::*;

   localparam int AW = $clog2(CAPACITY + 1);
   localparam int FW = $clog2(CAPACITY + 1) + 1;

   entry_type         mem [CAPACITY+1];
   logic [AW-1:0]     rd_addr;
   logic              rd_en;
   entry_type         rd_data_ff;
   logic [AW-1:0]     wr_addr;
   logic              wr_en;
   entry_type         wr_data;

   state_type         state_ff, state_in;
   logic              keep_largest_ff;
   logic [CAP_W-1:0]  capacity_ff;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW-1:0]     pos_ff, pos_in;
   logic              side_ff, side_in;
   entry_type         cur_ff, cur_in;
   entry_type         best_ff, best_in;
   logic [FW-1:0]     best_pos_ff, best_pos_in;
   entry_type         new_ff;
   logic              take_ff, take_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   entry_type         head_ff, head_in;
   logic [FW-1:0]     cap_eff;
   logic [FW-1:0]     child;

   function automatic logic above(input logic kl, input logic [KEY_W-1:0] a,
                                  input logic [KEY_W-1:0] b);
      above = kl ? (a < b) : (a > b);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      if (capacity_ff == '0) cap_eff = FW'(1);
      else if (FW'(capacity_ff) > FW'(CAPACITY)) cap_eff = FW'(CAPACITY);
      else cap_eff = FW'(capacity_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fill_ff         <= '0;
         keep_largest_ff <= 1'b0;
         capacity_ff     <= CAP_W'(64);
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_KEEP_LARGEST:    keep_largest_ff <= csr_data[0];
               CSR_CAPACITY_IN_USE: capacity_ff     <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      side_ff     <= side_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      take_ff     <= take_in;
      slot_ff     <= slot_in;
      head_ff     <= head_in;
      if (state_ff == ST_IDLE && start) begin
         new_ff.key    <= req_key_value;
         new_ff.first  <= req_first_index;
         new_ff.second <= req_second_index;
         new_ff.slot   <= '0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      side_in     = side_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      take_in     = take_ff;
      slot_in     = slot_ff;
      head_in     = head_ff;
      rd_en       = 1'b0;
      rd_addr     = AW'(1);
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = cur_ff;
      child       = {pos_ff[FW-2:0], 1'b0} + FW'(side_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_HEAD_RD;
               take_in  = 1'b0;
               slot_in  = '0;
               side_in  = 1'b0;
               if (fill_ff < cap_eff) begin
                  take_in  = 1'b1;
                  slot_in  = SLOT_W'(fill_ff);
                  state_in = ST_BUB_RD;
                  fill_in  = fill_ff + FW'(1);
                  pos_in   = fill_ff + FW'(1);
               end
            end
         end
         ST_HEAD_RD: begin
            // read the root into head_ff; if not yet taken, compare it with the new word
            if (!side_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               side_in  = 1'b1;
            end else begin
               head_in  = rd_data_ff;
               side_in  = 1'b0;
               if (take_ff || fill_ff == '0 || !above(keep_largest_ff, rd_data_ff.key,
                                                      new_ff.key)) begin
                  state_in = ST_DONE;
               end else begin
                  take_in  = 1'b1;
                  slot_in  = rd_data_ff.slot;
                  state_in = ST_LAST_RD;
               end
            end
         end
         ST_LAST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(fill_ff);
            fill_in  = fill_ff - FW'(1);
            state_in = ST_LAST_WAIT;
         end
         ST_LAST_WAIT: begin
            cur_in   = rd_data_ff;
            pos_in   = FW'(1);
            side_in  = 1'b0;
            state_in = ST_SINK_RD;
         end
         ST_SINK_RD: begin
            // cur_ff sits logically at pos_ff; probe children in turn
            if (child > fill_ff) begin
               if (side_ff) begin
                  state_in = ST_SINK_CMP;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(pos_ff);
                  wr_data = cur_ff;
                  fill_in = fill_ff + FW'(1);
                  pos_in  = fill_ff + FW'(1);
                  state_in = ST_BUB_RD;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(child);
               state_in = ST_SINK_WAIT;
               if (!side_ff) begin
                  best_in     = cur_ff;
                  best_pos_in = pos_ff;
               end
            end
         end
         ST_SINK_WAIT: begin
            if (above(keep_largest_ff, rd_data_ff.key, best_ff.key)) begin
               best_in     = rd_data_ff;
               best_pos_in = child;
            end
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = ST_SINK_RD;
            end else begin
               state_in = ST_SINK_CMP;
            end
         end
         ST_SINK_CMP: begin
            side_in = 1'b0;
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ff);
            if (best_pos_ff == pos_ff) begin
               wr_data  = cur_ff;
               fill_in  = fill_ff + FW'(1);
               pos_in   = fill_ff + FW'(1);
               state_in = ST_BUB_RD;
            end else begin
               wr_data  = best_ff;
               pos_in   = best_pos_ff;
               state_in = ST_SINK_RD;
            end
         end
         ST_BUB_RD: begin
            // new word sits logically at pos_ff
            cur_in      = new_ff;
            cur_in.slot = slot_ff;
            if (pos_ff <= FW'(1)) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(pos_ff);
               wr_data  = cur_in;
               side_in  = 1'b0;
               state_in = ST_HEAD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(pos_ff >> 1);
               state_in = ST_BUB_WAIT;
            end
         end
         ST_BUB_WAIT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ff);
            if (above(keep_largest_ff, cur_ff.key, rd_data_ff.key)) begin
               wr_data  = rd_data_ff;
               pos_in   = pos_ff >> 1;
               state_in = ST_BUB_RD;
            end else begin
               wr_data  = cur_ff;
               side_in  = 1'b0;
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_WAIT: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_DONE);
   assign rsp_accepted          = take_ff;
   assign rsp_slot_number       = slot_ff;
   assign rsp_head_key          = (fill_ff == '0) ? '0 : head_ff.key;
   assign rsp_head_first_index  = (fill_ff == '0) ? '0 : head_ff.first;
   assign rsp_head_second_index = (fill_ff == '0) ? '0 : head_ff.second;

   `BTK_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(CAPACITY), "fill above capacity")
   `BTK_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "response held two cycles")
   `BTK_ASSERT_IMP(a_rej_slot, clock, reset, rsp_valid && !rsp_accepted, rsp_slot_number == '0, "rejected word carries slot")
endmodule
